>>> hdl/temp_sensor_frame_checker_top_defines.svh
// Assertion macros used by the frame checker assertion file.
`ifndef TEMP_SENSOR_FRAME_CHECKER_TOP_DEFINES_SVH
`define TEMP_SENSOR_FRAME_CHECKER_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define TSFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/tsfc_pkg.sv
// Package: types, constants and CRC step of the scratchpad frame checker.
`timescale 1ns / 1ps

package tsfc_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_ERR  = 2'd1,
    STATUS_RESERVED = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_e;

  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] CFG_MIN_RAW_TEMP = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_MAX_RAW_TEMP = 2'd1;

  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam logic [3:0]  CRC_BYTE_COUNT = 4'd8;
  localparam logic [3:0]  FRAME_DONE     = 4'd9;
  localparam logic [15:0] RAW_RESERVED_A = 16'h0000;
  localparam logic [15:0] RAW_RESERVED_B = 16'h0550;
  localparam logic [15:0] RAW_RESERVED_C = 16'hFFFF;

  localparam logic signed [15:0] MIN_RAW_RESET = 16'sd80;
  localparam logic signed [15:0] MAX_RAW_RESET = 16'sd800;

  // Reflected CRC-8 over one byte, LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    logic       fb;
    crc  = crc_in;
    data = data_in;
    for (int b = 0; b < 8; b++) begin
      fb   = crc[0] ^ data[0];
      crc  = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      data = {1'b0, data[7:1]};
    end
    return crc;
  endfunction

endpackage

>>> hdl/temp_sensor_frame_checker_top.sv
// Top level: scratchpad frame checker with CRC-8, reserved and range tests.
// The result is registered: it is valid in the cycle after the ninth byte is accepted.
// Throughput: one byte per cycle; the CRC step for a byte is combinational
// logic. Input ready drops only while a finished result waits downstream.
// Reset (async, active low): frame count, CRC and result valid clear; limits
// return to 80 and 800 sixteenths of a degree.
`timescale 1ns / 1ps

module temp_sensor_frame_checker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [tsfc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [15:0]                        cfg_wdata_i,
  // byte input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         frame_byte_i,
  input  logic                               frame_start_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tsfc_pkg::status_e                  status_o,
  output logic signed [15:0]                 temperature_o
);

  import tsfc_pkg::*;

  // Configured limits, signed sixteenths of a degree.
  logic signed [15:0] min_raw_q, max_raw_q;

  // Frame state.
  logic [3:0] byte_idx_q, byte_idx_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] temp_lo_q, temp_lo_d;
  logic [7:0] temp_hi_q, temp_hi_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic signed [15:0] temp_q, temp_d;

  logic       in_xact;
  logic [3:0] idx_eff;
  logic [7:0] crc_eff;
  logic       result_now;
  logic [15:0] raw_bits;
  logic signed [15:0] raw_s;

  // The result slot frees when the waiting result is taken this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xact    = in_valid_i && in_ready_o;

  // A start flag restarts the count and CRC before the byte is used.
  assign idx_eff = frame_start_i ? 4'd0 : byte_idx_q;
  assign crc_eff = frame_start_i ? 8'd0 : crc_q;

  assign raw_bits   = {temp_hi_q, temp_lo_q};
  assign raw_s      = $signed(raw_bits);
  assign result_now = in_xact && (idx_eff == CRC_BYTE_COUNT);

  // Frame tracking.
  always_comb begin
    byte_idx_d = byte_idx_q;
    crc_d      = crc_q;
    temp_lo_d  = temp_lo_q;
    temp_hi_d  = temp_hi_q;
    if (in_xact) begin
      byte_idx_d = idx_eff;
      crc_d      = crc_eff;
      if (idx_eff < CRC_BYTE_COUNT) begin
        crc_d      = crc8_update(crc_eff, frame_byte_i);
        byte_idx_d = idx_eff + 4'd1;
        if (idx_eff == 4'd0) begin
          temp_lo_d = frame_byte_i;
        end else if (idx_eff == 4'd1) begin
          temp_hi_d = frame_byte_i;
        end
      end else if (idx_eff == CRC_BYTE_COUNT) begin
        byte_idx_d = FRAME_DONE;
      end
      // past the CRC byte: ignored until the next start
    end
  end

  // Result evaluation: CRC first, then reserved patterns, then range.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    temp_d      = temp_q;
    if (result_now) begin
      out_valid_d = 1'b1;
      temp_d      = 16'sd0;
      if (crc_eff != frame_byte_i) begin
        status_d = STATUS_CRC_ERR;
      end else if (raw_bits == RAW_RESERVED_A || raw_bits == RAW_RESERVED_B ||
                   raw_bits == RAW_RESERVED_C) begin
        status_d = STATUS_RESERVED;
      end else if (raw_s < min_raw_q || raw_s > max_raw_q) begin
        status_d = STATUS_RANGE;
      end else begin
        status_d = STATUS_OK;
        temp_d   = raw_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_raw_q   <= MIN_RAW_RESET;
      max_raw_q   <= MAX_RAW_RESET;
      byte_idx_q  <= 4'd0;
      crc_q       <= 8'd0;
      temp_lo_q   <= 8'd0;
      temp_hi_q   <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_RAW_TEMP: min_raw_q <= $signed(cfg_wdata_i);
          CFG_MAX_RAW_TEMP: max_raw_q <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      byte_idx_q  <= byte_idx_d;
      crc_q       <= crc_d;
      temp_lo_q   <= temp_lo_d;
      temp_hi_q   <= temp_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    temp_q   <= temp_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign temperature_o = temp_q;

endmodule

>>> hdl/tsfc_checker.sv
// Port-level assertions for the frame checker, bound to the top level.
`timescale 1ns / 1ps
`include "temp_sensor_frame_checker_top_defines.svh"

module tsfc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             frame_start_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input tsfc_pkg::status_e                status_o,
  input logic signed [15:0]               temperature_o
);

  import tsfc_pkg::*;

  // stalled result holds
  `TSFC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(temperature_o), "result changed while stalled")

  // failed frames report zero temperature
  `TSFC_ASSERT(a_err_temp_zero, out_valid_o && status_o != STATUS_OK |-> temperature_o == 16'sd0, "nonzero temperature on error")

  // an OK reading is never a reserved pattern
  `TSFC_ASSERT(a_ok_not_reserved, out_valid_o && status_o == STATUS_OK |-> temperature_o != RAW_RESERVED_A && temperature_o != RAW_RESERVED_B && temperature_o != RAW_RESERVED_C, "reserved pattern reported OK")

  // a start byte never completes a frame
  `TSFC_ASSERT(a_start_no_result, in_valid_i && in_ready_o && frame_start_i |=> !$rose(out_valid_o), "result after start byte")

endmodule

bind temp_sensor_frame_checker_top tsfc_checker u_tsfc_checker (.*);
